### design/ffrx_pkg.sv
// Shared types, constants and CRC helper for the framed frame receiver.
`default_nettype none
package ffrx_pkg;
    localparam int FRAME_BYTES  = 512;
    localparam int HEADER_BYTES = 8;
    localparam int AW           = $clog2(FRAME_BYTES);
    localparam int MW           = AW + 1;
    localparam int CNT_W        = $clog2(HEADER_BYTES + FRAME_BYTES + 2);
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_SWAP = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_DISCARD = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_COMPARE = 2'd2,
        MODE_BUSY    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CRC     = 3'd1,
        ST_VERSION = 3'd2,
        ST_COMMAND = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_BUSY    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_MAGIC1  = 3'd0,
        REG_MAGIC2  = 3'd1,
        REG_VERSION = 3'd2,
        REG_FCMD    = 3'd3,
        REG_ACMD    = 3'd4
    } t_reg;

    typedef struct packed {
        logic [7:0] magic1;
        logic [7:0] magic2;
        logic [7:0] version;
        logic [7:0] ack_cmd;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        is_ack;
        logic [1:0]  rkind;
        logic [7:0]  rbyte;
        logic        swapped;
        logic [15:0] seq;
        logic        pending;
        t_status     status;
    } t_req;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage
`default_nettype wire

### design/framed_frame_receiver_with_ack.sv
// Top level: packet receiver, double frame store and reply path.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_kind, i_data_byte, i_read_address
//  output   | o_out_valid  | i_out_stall  | reply_kind/byte, last, swapped, ...
//  config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
//
// Each item is handled as a frame store read, then an execute step with the read data.
// An ack streams 9 bytes, one per cycle while the output is not stalled; items that reply wait for it to drain.
// After reset the frame store is zeroed, all 1024 bytes, with the input stalled.
`default_nettype none
module framed_frame_receiver_with_ack (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [8:0]  i_read_address,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_reply_kind,
    output logic [7:0]       o_reply_byte,
    output logic             o_last,
    output logic             o_swapped,
    output logic [15:0]      o_front_seq,
    output logic             o_frame_pending,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);
    import ffrx_pkg::*;

    localparam logic [CNT_W-1:0] C_HDR  = CNT_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] C_PEND = CNT_W'(HEADER_BYTES + FRAME_BYTES);
    localparam logic [CNT_W-1:0] C_LAST = CNT_W'(HEADER_BYTES + FRAME_BYTES + 1);

    logic [7:0] r_m1, r_m2, r_ver, r_fcmd, r_acmd;
    t_cfg       cfg;

    logic [7:0] mem [2*FRAME_BYTES];
    logic [7:0] r_rd;
    logic       mem_we;
    logic [MW-1:0] mem_wa, mem_ra;
    logic [7:0] mem_wd;

    logic          r_clr;
    logic [MW-1:0] r_clr_cnt;

    logic          r_front, n_front;
    logic          r_pending, n_pending;
    logic [15:0]   r_staged, n_staged;
    logic [15:0]   r_shown, n_shown;
    logic          r_shown_v, n_shown_v;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_rcrc, n_rcrc;
    logic [15:0]   r_pseq, n_pseq;
    logic [7:0]    r_hver, n_hver, r_hcmd, n_hcmd, r_hlen, n_hlen;
    t_status       r_herr, n_herr;
    t_mode         r_mode, n_mode;
    logic          r_match, n_match;

    logic          r_ex_v;
    logic [1:0]    r_ex_kind;
    logic [7:0]    r_ex_b;
    logic [8:0]    r_ex_addr;

    logic          accept, out_item, tx_empty;
    logic [AW-1:0] pay_idx;
    t_req          req;
    t_status       st;
    logic [15:0]   seq_in, len_in, crc_rx;

    assign cfg = '{magic1: r_m1, magic2: r_m2, version: r_ver, ack_cmd: r_acmd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= 8'hA5; r_m2 <= 8'h5A; r_ver <= 8'h01; r_fcmd <= 8'h01; r_acmd <= 8'h02;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAGIC1:  r_m1   <= i_cfg_data;
                REG_MAGIC2:  r_m2   <= i_cfg_data;
                REG_VERSION: r_ver  <= i_cfg_data;
                REG_FCMD:    r_fcmd <= i_cfg_data;
                REG_ACMD:    r_acmd <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    assign out_item = (i_kind == KIND_SWAP) || (i_kind == KIND_READ)
                    || ((i_kind == KIND_BYTE) && (r_cnt == C_LAST));
    assign o_in_stall = r_clr || r_ex_v || (out_item && !tx_empty);
    assign accept     = i_in_valid && !o_in_stall;

    assign pay_idx = AW'(r_cnt - C_HDR);
    always_comb begin
        if (i_kind == KIND_READ) begin
            mem_ra = {r_front, i_read_address[AW-1:0]};
        end else if (r_mode == MODE_COMPARE) begin
            mem_ra = {~r_front, pay_idx};
        end else begin
            mem_ra = {r_front, pay_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_ex_v    <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    r_clr <= 1'b0;
                end
            end
            r_ex_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex_kind <= i_kind;
            r_ex_b    <= i_data_byte;
            r_ex_addr <= i_read_address;
        end
    end

    assign seq_in = {r_ex_b, 8'h00} | 16'(r_pseq[7:0]);
    assign len_in = {r_ex_b, r_hlen};
    assign crc_rx = {r_ex_b, r_rcrc};

    always_comb begin
        n_front = r_front; n_pending = r_pending; n_staged = r_staged;
        n_shown = r_shown; n_shown_v = r_shown_v; n_cnt = r_cnt; n_crc = r_crc;
        n_rcrc = r_rcrc; n_pseq = r_pseq; n_hver = r_hver; n_hcmd = r_hcmd;
        n_hlen = r_hlen; n_herr = r_herr; n_mode = r_mode; n_match = r_match;
        req = '0;
        st  = ST_OK;
        mem_we = 1'b0;
        mem_wa = {~r_front, pay_idx};
        mem_wd = r_ex_b;
        if (r_clr) begin
            mem_we = 1'b1;
            mem_wa = r_clr_cnt;
            mem_wd = 8'h00;
        end else if (r_ex_v) begin
            unique case (r_ex_kind)
                KIND_BYTE: begin
                    if (r_cnt == '0 || (r_cnt == CNT_W'(1) && r_ex_b != r_m2)) begin
                        n_cnt = '0; n_crc = CRC_INIT; n_rcrc = '0; n_pseq = '0;
                        n_herr = ST_OK; n_mode = MODE_DISCARD; n_match = 1'b0;
                        if (r_ex_b == r_m1) begin
                            n_crc = crc_byte(CRC_INIT, r_ex_b);
                            n_cnt = CNT_W'(1);
                        end
                    end else if (r_cnt < C_HDR) begin
                        n_crc = crc_byte(r_crc, r_ex_b);
                        n_cnt = r_cnt + 1'b1;
                        unique case (r_cnt)
                            CNT_W'(2): n_hver = r_ex_b;
                            CNT_W'(3): n_hcmd = r_ex_b;
                            CNT_W'(4): n_pseq = {8'h00, r_ex_b};
                            CNT_W'(5): n_pseq = seq_in;
                            CNT_W'(6): n_hlen = r_ex_b;
                            CNT_W'(7): begin
                                if (r_hver != r_ver) begin
                                    n_herr = ST_VERSION;
                                end else if (r_hcmd != r_fcmd) begin
                                    n_herr = ST_COMMAND;
                                end else if (32'(len_in) != 32'(FRAME_BYTES)) begin
                                    n_herr = ST_LENGTH;
                                end else if (r_pending) begin
                                    if (r_pseq == r_staged) begin
                                        n_mode = MODE_COMPARE; n_match = 1'b1;
                                    end else begin
                                        n_mode = MODE_BUSY;
                                    end
                                end else begin
                                    n_mode  = MODE_WRITE;
                                    n_match = r_shown_v && (r_pseq == r_shown);
                                end
                            end
                            default: ;
                        endcase
                    end else if (r_cnt < C_PEND) begin
                        if (r_mode == MODE_WRITE) begin
                            mem_we = 1'b1;
                            if (r_ex_b != r_rd) n_match = 1'b0;
                        end else if (r_mode == MODE_COMPARE) begin
                            if (r_ex_b != r_rd) n_match = 1'b0;
                        end
                        n_crc = crc_byte(r_crc, r_ex_b);
                        n_cnt = r_cnt + 1'b1;
                    end else if (r_cnt == C_PEND) begin
                        n_rcrc = r_ex_b;
                        n_cnt  = r_cnt + 1'b1;
                    end else begin
                        if (crc_rx != r_crc) begin
                            st = ST_CRC;
                        end else if (r_herr != ST_OK) begin
                            st = r_herr;
                        end else if (r_mode == MODE_BUSY) begin
                            st = ST_BUSY;
                        end else if (r_mode == MODE_COMPARE) begin
                            st = r_match ? ST_OK : ST_BUSY;
                        end else if (r_mode == MODE_WRITE && !r_match) begin
                            n_staged  = r_pseq;
                            n_pending = 1'b1;
                        end
                        req.valid   = 1'b1;
                        req.is_ack  = 1'b1;
                        req.seq     = r_pseq;
                        req.status  = st;
                        req.pending = n_pending;
                        n_cnt = '0; n_crc = CRC_INIT; n_rcrc = '0; n_pseq = '0;
                        n_herr = ST_OK; n_mode = MODE_DISCARD; n_match = 1'b0;
                    end
                end
                KIND_SWAP: begin
                    if (r_pending) begin
                        n_front   = ~r_front;
                        n_pending = 1'b0;
                        n_shown   = r_staged;
                        n_shown_v = 1'b1;
                    end
                    req.valid   = 1'b1;
                    req.rkind   = KIND_SWAP;
                    req.swapped = r_pending;
                    req.seq     = n_shown;
                    req.pending = n_pending;
                end
                KIND_READ: begin
                    if (32'(r_ex_addr) < 32'(FRAME_BYTES)) begin
                        req.valid   = 1'b1;
                        req.rkind   = KIND_READ;
                        req.rbyte   = r_rd;
                        req.pending = r_pending;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= 1'b0; r_pending <= 1'b0; r_staged <= '0; r_shown <= '0;
            r_shown_v <= 1'b0; r_cnt <= '0; r_crc <= CRC_INIT; r_rcrc <= '0;
            r_pseq <= '0; r_hver <= '0; r_hcmd <= '0; r_hlen <= '0;
            r_herr <= ST_OK; r_mode <= MODE_DISCARD; r_match <= 1'b0;
        end else begin
            r_front <= n_front; r_pending <= n_pending; r_staged <= n_staged;
            r_shown <= n_shown; r_shown_v <= n_shown_v; r_cnt <= n_cnt;
            r_crc <= n_crc; r_rcrc <= n_rcrc; r_pseq <= n_pseq; r_hver <= n_hver;
            r_hcmd <= n_hcmd; r_hlen <= n_hlen; r_herr <= n_herr; r_mode <= n_mode;
            r_match <= n_match;
        end
    end

    ffrx_ack_tx u_tx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req),
        .i_cfg           (cfg),
        .o_empty         (tx_empty),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reply_kind    (o_reply_kind),
        .o_reply_byte    (o_reply_byte),
        .o_last          (o_last),
        .o_swapped       (o_swapped),
        .o_front_seq     (o_front_seq),
        .o_frame_pending (o_frame_pending)
    );
endmodule
`default_nettype wire

### design/ffrx_ack_tx.sv
// Output stage: result register and acknowledgement packet sequencer.
`default_nettype none
module ffrx_ack_tx (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ffrx_pkg::t_req  i_req,
    input  wire ffrx_pkg::t_cfg  i_cfg,
    output logic                 o_empty,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [1:0]           o_reply_kind,
    output logic [7:0]           o_reply_byte,
    output logic                 o_last,
    output logic                 o_swapped,
    output logic [15:0]          o_front_seq,
    output logic                 o_frame_pending
);
    import ffrx_pkg::*;

    logic        r_active, n_active;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_seq;
    logic [2:0]  r_st;
    logic        r_pend;
    logic        r_valid, n_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_last, r_swp;
    logic [15:0] r_dseq;
    logic        r_opend;
    logic        slot;
    logic [7:0]  ack_b;

    assign slot    = !r_valid || !i_out_stall;
    // free at the coming edge: no ack streaming and the result register empties
    assign o_empty = !r_active && slot;

    always_comb begin
        unique case (r_idx)
            4'd0:    ack_b = i_cfg.magic1;
            4'd1:    ack_b = i_cfg.magic2;
            4'd2:    ack_b = i_cfg.version;
            4'd3:    ack_b = i_cfg.ack_cmd;
            4'd4:    ack_b = r_seq[7:0];
            4'd5:    ack_b = r_seq[15:8];
            4'd6:    ack_b = {5'd0, r_st};
            4'd7:    ack_b = r_crc[7:0];
            default: ack_b = r_crc[15:8];
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_valid  = r_valid && i_out_stall;
        if (i_req.valid && i_req.is_ack) begin
            n_active = 1'b1;
            n_idx    = 4'd0;
            n_crc    = CRC_INIT;
        end else if (i_req.valid) begin
            n_valid = 1'b1;
        end else if (r_active && slot) begin
            n_valid = 1'b1;
            n_idx   = r_idx + 4'd1;
            if (r_idx < 4'd7) begin
                n_crc = crc_byte(r_crc, ack_b);
            end
            if (r_idx == 4'd8) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_idx    <= 4'd0;
            r_crc    <= CRC_INIT;
        end else begin
            r_active <= n_active;
            r_valid  <= n_valid;
            r_idx    <= n_idx;
            r_crc    <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.is_ack) begin
            r_seq  <= i_req.seq;
            r_st   <= i_req.status;
            r_pend <= i_req.pending;
        end
        if (i_req.valid && !i_req.is_ack) begin
            r_kind  <= i_req.rkind;
            r_byte  <= i_req.rbyte;
            r_last  <= 1'b1;
            r_swp   <= i_req.swapped;
            r_dseq  <= i_req.seq;
            r_opend <= i_req.pending;
        end else if (!i_req.valid && r_active && slot) begin
            r_kind  <= KIND_BYTE;
            r_byte  <= ack_b;
            r_last  <= (r_idx == 4'd8);
            r_swp   <= 1'b0;
            r_dseq  <= 16'd0;
            r_opend <= r_pend;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_reply_kind    = r_kind;
    assign o_reply_byte    = r_byte;
    assign o_last          = r_last;
    assign o_swapped       = r_swp;
    assign o_front_seq     = r_dseq;
    assign o_frame_pending = r_opend;
endmodule
`default_nettype wire

### tb/framed_frame_receiver_with_ack_chk.sv
// Checker for the framed frame receiver: predicts replies and compares them with the block.
module framed_frame_receiver_with_ack_chk
    import ffrx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [8:0]  i_read_address,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_reply_kind,
    input  wire logic [7:0]  i_reply_byte,
    input  wire logic        i_last,
    input  wire logic        i_swapped,
    input  wire logic [15:0] i_front_seq,
    input  wire logic        i_frame_pending,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    output int               o_errors,
    output int               o_outstanding,
    output int               o_acks,
    output int               o_swaps
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [7:0]  rbyte;
        logic        last;
        logic        swapped;
        logic [15:0] seq;
        logic        pending;
    } t_reply;

    t_reply reply_q[$];

    logic [7:0]  cfg_m1, cfg_m2, cfg_ver, cfg_fcmd, cfg_acmd;
    logic [7:0]  store [0:2*FRAME_BYTES-1];
    logic        front_sel, pending, shown_ok, pay_same;
    logic [15:0] staged_seq, shown_seq, run_crc, rx_crc, pkt_seq;
    int          count;
    logic [7:0]  hdr [0:HEADER_BYTES-1];
    t_status     hdr_err;
    t_mode       mode;

    assign o_outstanding = reply_q.size();

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        return c;
    endfunction

    task automatic restart_rx();
        count = 0; run_crc = 16'hFFFF; rx_crc = 0; pkt_seq = 0;
        hdr_err = ST_OK; mode = MODE_DISCARD; pay_same = 0;
    endtask

    task automatic take_sync(logic [7:0] b);
        hdr[0] = b; run_crc = crc_step(16'hFFFF, b); count = 1;
    endtask

    task automatic header_complete();
        logic [15:0] len;
        len = {hdr[7], hdr[6]};
        pkt_seq = {hdr[5], hdr[4]};
        if (hdr[2] != cfg_ver) hdr_err = ST_VERSION;
        else if (hdr[3] != cfg_fcmd) hdr_err = ST_COMMAND;
        else if (len != FRAME_BYTES) hdr_err = ST_LENGTH;
        else if (pending) begin
            if (pkt_seq == staged_seq) begin
                mode = MODE_COMPARE; pay_same = 1;
            end else begin
                mode = MODE_BUSY;
            end
        end else begin
            mode = MODE_WRITE;
            pay_same = shown_ok && pkt_seq == shown_seq;
        end
    endtask

    task automatic predict_byte(logic [7:0] b);
        int p;
        t_status st;
        logic [7:0] ack [0:8];
        logic [15:0] c;
        t_reply r;
        if (count == 0) begin
            if (b == cfg_m1) take_sync(b);
        end else if (count == 1 && b != cfg_m2) begin
            restart_rx();
            if (b == cfg_m1) take_sync(b);
        end else if (count < HEADER_BYTES) begin
            hdr[count] = b; run_crc = crc_step(run_crc, b); count++;
            if (count == HEADER_BYTES) header_complete();
        end else if (count < HEADER_BYTES + FRAME_BYTES) begin
            p = count - HEADER_BYTES;
            if (mode == MODE_WRITE) begin
                store[(!front_sel) * FRAME_BYTES + p] = b;
                if (pay_same && b != store[front_sel * FRAME_BYTES + p]) pay_same = 0;
            end else if (mode == MODE_COMPARE) begin
                if (b != store[(!front_sel) * FRAME_BYTES + p]) pay_same = 0;
            end
            run_crc = crc_step(run_crc, b); count++;
        end else if (count == HEADER_BYTES + FRAME_BYTES) begin
            rx_crc = {8'h00, b}; count++;
        end else begin
            rx_crc[15:8] = b;
            if (rx_crc != run_crc) st = ST_CRC;
            else if (hdr_err != ST_OK) st = hdr_err;
            else if (mode == MODE_BUSY) st = ST_BUSY;
            else if (mode == MODE_COMPARE) st = pay_same ? ST_OK : ST_BUSY;
            else begin
                st = ST_OK;
                if (mode == MODE_WRITE && !pay_same) begin
                    staged_seq = pkt_seq; pending = 1;
                end
            end
            ack[0] = cfg_m1; ack[1] = cfg_m2; ack[2] = cfg_ver; ack[3] = cfg_acmd;
            ack[4] = pkt_seq[7:0]; ack[5] = pkt_seq[15:8]; ack[6] = {5'd0, st};
            c = 16'hFFFF;
            for (int i = 0; i < 7; i++) c = crc_step(c, ack[i]);
            ack[7] = c[7:0]; ack[8] = c[15:8];
            restart_rx();
            for (int i = 0; i < 9; i++) begin
                r = '{rkind: 2'd0, rbyte: ack[i], last: (i == 8), swapped: 0,
                      seq: 0, pending: pending};
                reply_q.push_back(r);
            end
            o_acks++;
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_reply r;
        logic did;
        if (!i_rst_n) begin
            cfg_m1 <= 8'hA5; cfg_m2 <= 8'h5A; cfg_ver <= 8'h01;
            cfg_fcmd <= 8'h01; cfg_acmd <= 8'h02;
            for (int i = 0; i < 2*FRAME_BYTES; i++) store[i] = 0;
            for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 0;
            front_sel = 0; pending = 0; staged_seq = 0; shown_seq = 0; shown_ok = 0;
            restart_rx();
            reply_q.delete();
            o_errors = 0; o_acks = 0; o_swaps = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_MAGIC1:  cfg_m1 <= i_cfg_data;
                    REG_MAGIC2:  cfg_m2 <= i_cfg_data;
                    REG_VERSION: cfg_ver <= i_cfg_data;
                    REG_FCMD:    cfg_fcmd <= i_cfg_data;
                    REG_ACMD:    cfg_acmd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (t_kind'(i_kind))
                    KIND_BYTE: predict_byte(i_data_byte);
                    KIND_SWAP: begin
                        did = pending;
                        if (pending) begin
                            front_sel = !front_sel; pending = 0;
                            shown_seq = staged_seq; shown_ok = 1; o_swaps++;
                        end
                        r = '{rkind: 2'd1, rbyte: 0, last: 1, swapped: did,
                              seq: shown_seq, pending: pending};
                        reply_q.push_back(r);
                    end
                    KIND_READ: begin
                        r = '{rkind: 2'd2, rbyte: store[front_sel * FRAME_BYTES
                              + i_read_address], last: 1, swapped: 0, seq: 0,
                              pending: pending};
                        reply_q.push_back(r);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    report("unexpected reply transfer", 32'd1, 32'd0);
                end else begin
                    r = reply_q.pop_front();
                    if (i_reply_kind != r.rkind) report("reply_kind", i_reply_kind, r.rkind);
                    if (i_reply_byte != r.rbyte) report("reply_byte", i_reply_byte, r.rbyte);
                    if (i_last != r.last) report("last", i_last, r.last);
                    if (i_swapped != r.swapped) report("swapped", i_swapped, r.swapped);
                    if (i_front_seq != r.seq)
                        report("front_seq", i_front_seq, r.seq);
                    if (i_frame_pending != r.pending)
                        report("frame_pending", i_frame_pending, r.pending);
                end
            end
        end
    end
endmodule

### tb/framed_frame_receiver_with_ack_tb.sv
// Testbench top: stimulus, clock, reset and verdict for the framed frame receiver.
module framed_frame_receiver_with_ack_tb;
    import ffrx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 10_000_000;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
    logic [1:0]  kind = 0, reply_kind;
    logic [7:0]  data_byte = 0, reply_byte;
    logic [8:0]  read_address = 0;
    logic        last, swapped, frame_pending;
    logic [15:0] front_seq;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = 0;
    logic [7:0]  cfg_data = 0;
    int          errors, outstanding, acks, swaps, cycles = 0;
    int          send_idle = 0, recv_idle = 0, items = 0;
    logic [7:0]  m1 = 8'hA5, m2 = 8'h5A, ver = 8'h01, fcmd = 8'h01;
    logic [7:0]  payload [0:FRAME_BYTES-1];

    framed_frame_receiver_with_ack u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_data_byte(data_byte), .i_read_address(read_address),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_reply_kind(reply_kind),
        .o_reply_byte(reply_byte), .o_last(last), .o_swapped(swapped),
        .o_front_seq(front_seq), .o_frame_pending(frame_pending),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    framed_frame_receiver_with_ack_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_data_byte(data_byte), .i_read_address(read_address),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_reply_kind(reply_kind),
        .i_reply_byte(reply_byte), .i_last(last), .i_swapped(swapped),
        .i_front_seq(front_seq), .i_frame_pending(frame_pending),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_outstanding(outstanding), .o_acks(acks), .o_swaps(swaps)
    );

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        out_stall <= ($urandom_range(99) < recv_idle);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("framed_frame_receiver_with_ack_tb failed");
            $finish;
        end
    end

    // one transfer; valid stays high into the next item when no gap is drawn
    task automatic send(t_kind k, logic [7:0] b, logic [8:0] a);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; kind <= k; data_byte <= b; read_address <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items++;
    endtask

    task automatic finish_item();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_crc_byte(inout logic [15:0] crc, input logic [7:0] b);
        crc = u_chk.crc_step(crc, b);
        send(KIND_BYTE, b, 0);
    endtask

    // whole packet; err: 0 none, 1 bad crc, 2 version, 3 command, 4 length
    task automatic send_packet(logic [15:0] seq, int err);
        logic [15:0] crc, len;
        crc = 16'hFFFF;
        len = (err == 4) ? 16'd511 : 16'(FRAME_BYTES);
        send_crc_byte(crc, m1);
        send_crc_byte(crc, m2);
        send_crc_byte(crc, (err == 2) ? ver + 8'd1 : ver);
        send_crc_byte(crc, (err == 3) ? fcmd + 8'd1 : fcmd);
        send_crc_byte(crc, seq[7:0]);
        send_crc_byte(crc, seq[15:8]);
        send_crc_byte(crc, len[7:0]);
        send_crc_byte(crc, len[15:8]);
        for (int i = 0; i < FRAME_BYTES; i++) send_crc_byte(crc, payload[i]);
        if (err == 1) crc ^= 16'h0100 << $urandom_range(7);
        send(KIND_BYTE, crc[7:0], 0);
        send(KIND_BYTE, crc[15:8], 0);
    endtask

    task automatic fill_payload(int style);
        for (int i = 0; i < FRAME_BYTES; i++)
            payload[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom);
    endtask

    task automatic drain();
        finish_item();
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(t_reg idx, logic [7:0] v);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_MAGIC1:  m1 = v;
            REG_MAGIC2:  m2 = v;
            REG_VERSION: ver = v;
            REG_FCMD:    fcmd = v;
            default: ;
        endcase
    endtask

    task automatic random_items(int n);
        int r;
        logic [15:0] seq;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                seq = ($urandom_range(1) && swaps > 0) ? u_chk.shown_seq
                    : ($urandom_range(1) ? u_chk.staged_seq : 16'($urandom));
                if ($urandom_range(3) != 0) fill_payload(2);
                send_packet(seq, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
            end else if (r < 60) begin
                send(KIND_SWAP, 8'($urandom), 9'($urandom));
            end else if (r < 80) begin
                send(KIND_READ, 8'($urandom), 9'($urandom));
            end else if (r < 90) begin
                send(KIND_BYTE, ($urandom_range(1)) ? m1 : 8'($urandom), 9'($urandom));
            end else if (r < 95) begin
                send(KIND_BYTE, m1, 0);
                send(KIND_BYTE, 8'($urandom), 0);
            end else begin
                send(t_kind'(2'd3), 8'($urandom), 9'($urandom));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        // directed: sync hunting, reads of zeroed store, empty swap, all statuses
        send(KIND_READ, 0, 9'd0);
        send(KIND_READ, 0, 9'd511);
        send(KIND_SWAP, 0, 0);
        send(t_kind'(2'd3), 8'hFF, 9'h1FF);
        send(KIND_BYTE, 8'h00, 0);
        send(KIND_BYTE, m1, 0);
        send(KIND_BYTE, m1, 0);
        send(KIND_BYTE, 8'h00, 0);
        fill_payload(1);
        send_packet(16'hFFFF, 2);
        send_packet(16'h0000, 3);
        send_packet(16'h1234, 4);
        send_packet(16'h1234, 1);
        send_packet(16'h0000, 0);
        send_packet(16'h0000, 0);
        fill_payload(2);
        send_packet(16'h0000, 0);
        send_packet(16'h0001, 0);
        send(KIND_READ, 0, 9'd5);
        send(KIND_SWAP, 0, 0);
        send(KIND_READ, 0, 9'd5);
        send_packet(16'h0000, 0);
        send_packet(16'hFFFF, 0);
        drain();
        send_idle = 10; recv_idle = 65;
        random_items(140);
        drain();
        write_reg(REG_MAGIC1, 8'hFF);
        write_reg(REG_MAGIC2, 8'h00);
        write_reg(REG_VERSION, 8'hFF);
        write_reg(REG_FCMD, 8'h00);
        write_reg(REG_ACMD, 8'hFF);
        send_idle = 65; recv_idle = 10;
        random_items(140);
        drain();
        write_reg(REG_MAGIC1, 8'h00);
        write_reg(REG_MAGIC2, 8'hFF);
        write_reg(REG_VERSION, 8'h00);
        write_reg(REG_FCMD, 8'hFF);
        write_reg(REG_ACMD, 8'h00);
        send_idle = 0; recv_idle = 0;
        random_items(140);
        drain();
        $display("%0d items sent, %0d acknowledgements and %0d frame swaps predicted",
                 items, acks, swaps);
        if (errors == 0) begin
            $display("framed_frame_receiver_with_ack_tb passed");
        end else begin
            $display("framed_frame_receiver_with_ack_tb failed");
        end
        $finish;
    end
endmodule

### files.f
design/ffrx_pkg.sv
design/ffrx_ack_tx.sv
design/framed_frame_receiver_with_ack.sv
tb/framed_frame_receiver_with_ack_chk.sv
tb/framed_frame_receiver_with_ack_tb.sv
